@@ rtl/pe_pkg.sv @@
// Shared types, constants and saturation helper for the polynomial evaluator.
`timescale 1ns / 1ps

package pe_pkg;

    // Field widths of the streams and the configuration port.
    localparam int X_W       = 16;
    localparam int COEF_W    = 32;
    localparam int VAL_W     = 48;
    localparam int WIDE_W    = 64;
    localparam int COEF_REGS = 8;
    localparam int CFG_IDX_W = 4;

    // Fixed-point constants in Q32.16.
    localparam logic signed [VAL_W-1:0] VAL_ONE = 48'sh0000_0001_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 48'sh8000_0000_0000;

    // Work item that travels down the chain of cells.
    typedef struct packed {
        logic signed [X_W-1:0]   x;
        logic signed [VAL_W-1:0] p;
        logic signed [VAL_W-1:0] acc;
        logic                    flag;
    } pe_token_t;

    // Saturated value and a hit flag.
    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] val;
    } pe_sat_t;

    // Clamp a 64-bit signed value to the 48-bit signed range.
    function automatic pe_sat_t sat48(input logic signed [WIDE_W-1:0] v);
        pe_sat_t r;
        if ((&v[WIDE_W-1:VAL_W-1]) || !(|v[WIDE_W-1:VAL_W-1])) begin
            r.hit = 1'b0;
            r.val = v[VAL_W-1:0];
        end
        else begin
            r.hit = 1'b1;
            r.val = v[WIDE_W-1] ? VAL_MIN : VAL_MAX;
        end
        return r;
    endfunction

endpackage

@@ rtl/pe_if.sv @@
// Handshake interfaces for the sample, result and configuration channels.
`timescale 1ns / 1ps

interface pe_sample_if;
    logic                            valid;
    logic                            ready;
    logic signed [pe_pkg::X_W-1:0]   x_value;

    modport source (output valid, output x_value, input ready);
    modport sink   (input valid, input x_value, output ready);
endinterface

interface pe_result_if;
    logic                            valid;
    logic                            ready;
    logic signed [pe_pkg::VAL_W-1:0] y_value;
    logic                            saturated;

    modport source (output valid, output y_value, output saturated, input ready);
    modport sink   (input valid, input y_value, input saturated, output ready);
endinterface

interface pe_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pe_pkg::CFG_IDX_W-1:0]      index;
    logic [pe_pkg::COEF_W-1:0]         data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/pe_cell.sv @@
// One term of the polynomial: multiply, accumulate and advance the power.
`timescale 1ns / 1ps

module pe_cell #(
    parameter bit HAS_POWER = 1'b1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              ce,
    input  logic                              in_valid,
    input  pe_pkg::pe_token_t                 in_tok,
    input  logic signed [pe_pkg::COEF_W-1:0]  coef,
    output logic                              out_valid,
    output pe_pkg::pe_token_t                 out_tok
);
    import pe_pkg::*;

    localparam int HALF_W = VAL_W / 2;
    localparam int PROD_W = COEF_W + VAL_W;
    localparam int FRAC_W = 16;
    localparam int X_FRAC = 8;

    // Stage 1 registers: partial products and the power product.
    logic                                s1_valid_reg;
    pe_token_t                           s1_tok_reg;
    logic signed [COEF_W+HALF_W:0]       pp_lo_reg, pp_lo_next;
    logic signed [COEF_W+HALF_W-1:0]     pp_hi_reg, pp_hi_next;
    logic signed [WIDE_W-1:0]            px_reg, px_next;

    // Stage 2 registers: truncated term and the new power.
    logic                                s2_valid_reg;
    pe_token_t                           s2_tok_reg, s2_tok_next;
    logic signed [WIDE_W-1:0]            term_reg, term_next;
    logic signed [PROD_W-1:0]            prod;
    pe_sat_t                             p_sat;

    // Stage 3 registers: the saturated running sum.
    logic                                out_valid_reg;
    pe_token_t                           out_tok_reg, out_tok_next;
    logic signed [WIDE_W-1:0]            sum;
    pe_sat_t                             a_sat;

    // Split the power into a low unsigned half and a high signed half.
    always_comb
    begin
        pp_lo_next = coef * $signed({1'b0, in_tok.p[HALF_W-1:0]});
        pp_hi_next = coef * $signed(in_tok.p[VAL_W-1:HALF_W]);
        px_next    = in_tok.p * in_tok.x;
    end

    // Recombine the product, floor it to Q32.16 and form the next power.
    always_comb
    begin
        prod        = $signed({pp_hi_reg, {HALF_W{1'b0}}}) + PROD_W'(pp_lo_reg);
        term_next   = prod[PROD_W-1:FRAC_W];
        p_sat       = sat48(px_reg >>> X_FRAC);
        s2_tok_next = s1_tok_reg;
        if (HAS_POWER)
        begin
            s2_tok_next.p    = p_sat.val;
            s2_tok_next.flag = s1_tok_reg.flag | p_sat.hit;
        end
    end

    // Add the term to the accumulator with saturation.
    always_comb
    begin
        sum               = WIDE_W'(s2_tok_reg.acc) + term_reg;
        a_sat             = sat48(sum);
        out_tok_next      = s2_tok_reg;
        out_tok_next.acc  = a_sat.val;
        out_tok_next.flag = s2_tok_reg.flag | a_sat.hit;
    end

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // Payload of the three stages.
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s1_tok_reg  <= in_tok;
            pp_lo_reg   <= pp_lo_next;
            pp_hi_reg   <= pp_hi_next;
            px_reg      <= px_next;
            s2_tok_reg  <= s2_tok_next;
            term_reg    <= term_next;
            out_tok_reg <= out_tok_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tok   = out_tok_reg;

endmodule

@@ rtl/polynomial_evaluator.sv @@
// Top level of the polynomial evaluator: coefficient registers and the chain of cells.
`timescale 1ns / 1ps

// The evaluator computes y = sum of coef_j * x^j for j below NUM_TERMS, with x in
// signed Q8.8, coefficients in signed Q16.16 and y in signed Q32.16; products are
// floored and both the running power and the sum saturate at the 48-bit bounds,
// which sets the saturated flag. It takes one sample per cycle while the chain moves,
// with one cell per term and a three-stage multiply, recombine and accumulate path in
// each cell. The whole chain holds while a finished result waits at the output, so
// the sample ready follows the result ready. Coefficient writes are taken in every
// cycle, reset clears all coefficients to zero, and a write with an index beyond
// coef_7 is dropped.
module polynomial_evaluator #(
    parameter int NUM_TERMS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    pe_sample_if.sink   sample,
    pe_result_if.source result,
    pe_cfg_if.sink      cfg
);
    import pe_pkg::*;

    logic signed [COEF_W-1:0] coef_reg [COEF_REGS];
    pe_token_t                tok   [NUM_TERMS+1];
    logic                     valid [NUM_TERMS+1];
    logic                     ce;

    // Coefficient register writes.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COEF_REGS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            for (int i = 0; i < COEF_REGS; i++)
            begin
                if (cfg.index == CFG_IDX_W'(i))
                begin
                    coef_reg[i] <= cfg.data;
                end
            end
        end
    end

    // The chain moves whenever the output slot is free or being emptied.
    assign ce           = !valid[NUM_TERMS] || result.ready;
    assign sample.ready = ce;

    // Head of the chain: power 1.0, empty sum.
    assign valid[0] = sample.valid;
    assign tok[0]   = '{x: sample.x_value, p: VAL_ONE, acc: '0, flag: 1'b0};

    // One cell per term; the last one forms no further power.
    for (genvar j = 0; j < NUM_TERMS; j++)
    begin : g_cell
        pe_cell #(
            .HAS_POWER (j < NUM_TERMS - 1)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ce        (ce),
            .in_valid  (valid[j]),
            .in_tok    (tok[j]),
            .coef      (coef_reg[j]),
            .out_valid (valid[j+1]),
            .out_tok   (tok[j+1])
        );
    end

    // The last cell's output stage is the result register.
    assign result.valid     = valid[NUM_TERMS];
    assign result.y_value   = tok[NUM_TERMS].acc;
    assign result.saturated = tok[NUM_TERMS].flag;

endmodule

@@ sim/polynomial_evaluator_checker.sv @@
// Checker for the polynomial evaluator: tracks coefficients, predicts each result and compares.
`timescale 1ns / 1ps

module polynomial_evaluator_checker
    import pe_pkg::*;
#(
    parameter int NUM_TERMS = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample_valid,
    input  logic                    sample_ready,
    input  logic signed [X_W-1:0]   sample_x,
    input  logic                    result_valid,
    input  logic                    result_ready,
    input  logic signed [VAL_W-1:0] result_y,
    input  logic                    result_saturated,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [COEF_W-1:0]       cfg_data,
    output int                      fail_count,
    output int                      results_owed
);

    // Products are formed exactly in this width before the floor shift.
    localparam int PROD_W = 80;
    localparam int COEF_IDX_W = $clog2(COEF_REGS);
    localparam logic signed [PROD_W-1:0] WIDE_MAX = 80'sh7FFF_FFFF_FFFF;
    localparam logic signed [PROD_W-1:0] WIDE_MIN = -WIDE_MAX - 1;

    typedef struct packed {
        logic signed [VAL_W-1:0] y;
        logic                    sat;
    } poly_result_t;

    logic signed [COEF_W-1:0] coef_copy [COEF_REGS];
    poly_result_t             poly_results_due [$];
    poly_result_t             due;

    // Clamp to the 48-bit signed range; the top bit tells whether a bound was hit.
    function automatic logic [VAL_W:0] clamp_q32(input logic signed [PROD_W-1:0] v);
        if (v > WIDE_MAX)
            return {1'b1, VAL_MAX};
        if (v < WIDE_MIN)
            return {1'b1, VAL_MIN};
        return {1'b0, v[VAL_W-1:0]};
    endfunction

    // Sum of coef_j * x^j with the power built up by repeated multiplication.
    function automatic poly_result_t poly_value(input logic signed [X_W-1:0] x);
        poly_result_t            r;
        logic signed [VAL_W-1:0] power;
        logic signed [VAL_W-1:0] sum;
        logic signed [PROD_W-1:0] prod;
        logic                    hit;
        r.sat = 1'b0;
        power = VAL_ONE;
        sum   = '0;
        for (int j = 0; j < NUM_TERMS; j++)
        begin
            // The term is floored to Q32.16 and added with saturation.
            prod = coef_copy[j] * power;
            prod = sum + (prod >>> 16);
            {hit, sum} = clamp_q32(prod);
            r.sat = r.sat | hit;
            // No power is formed beyond the last term.
            if (j + 1 < NUM_TERMS)
            begin
                prod = power * x;
                {hit, power} = clamp_q32(prod >>> 8);
                r.sat = r.sat | hit;
            end
        end
        r.y = sum;
        return r;
    endfunction

    // Follow the transfers on all three channels.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COEF_REGS; i++)
                coef_copy[i] <= '0;
            poly_results_due.delete();
            results_owed <= 0;
        end
        else
        begin
            // Writes with an index past the last coefficient are dropped.
            if (cfg_valid && cfg_ready && cfg_index < COEF_REGS)
                coef_copy[cfg_index[COEF_IDX_W-1:0]] <= cfg_data;

            // Each result is matched against the oldest prediction.
            if (result_valid && result_ready)
            begin
                if (poly_results_due.size() == 0)
                begin
                    $error("unexpected result: y_value %0d, saturated %0b",
                           result_y, result_saturated);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    due = poly_results_due.pop_front();
                    if (result_y !== due.y)
                    begin
                        $error("y_value mismatch: expected %0d, got %0d", due.y, result_y);
                        fail_count = fail_count + 1;
                    end
                    if (result_saturated !== due.sat)
                    begin
                        $error("saturated mismatch: expected %0b, got %0b",
                               due.sat, result_saturated);
                        fail_count = fail_count + 1;
                    end
                end
            end

            if (sample_valid && sample_ready)
                poly_results_due.insert(poly_results_due.size(), poly_value(sample_x));

            results_owed <= poly_results_due.size();
        end
    end

endmodule

@@ sim/polynomial_evaluator_tb.sv @@
// Testbench top for the polynomial evaluator: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module polynomial_evaluator_tb;

    import pe_pkg::*;

    localparam int NUM_TERMS      = 8;
    localparam int SET_COUNT      = 13;
    localparam int SAMPLES_PER_SET = 100;
    localparam int QUIET_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 3 * NUM_TERMS + 8;
    localparam int MAX_BURST      = 17;

    typedef logic [COEF_W-1:0] coef_set_t [COEF_REGS];

    logic clk;
    logic rst_n;
    int   fail_count;
    int   results_owed;
    int   gap_pct;
    int   stall_pct;
    int   quiet_cycles;

    pe_sample_if smp ();
    pe_result_if res ();
    pe_cfg_if    cfg ();

    polynomial_evaluator #(
        .NUM_TERMS (NUM_TERMS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (smp),
        .result (res),
        .cfg    (cfg)
    );

    polynomial_evaluator_checker #(
        .NUM_TERMS (NUM_TERMS)
    ) poly_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample_valid     (smp.valid),
        .sample_ready     (smp.ready),
        .sample_x         (smp.x_value),
        .result_valid     (res.valid),
        .result_ready     (res.ready),
        .result_y         (res.y_value),
        .result_saturated (res.saturated),
        .cfg_valid        (cfg.valid),
        .cfg_ready        (cfg.ready),
        .cfg_index        (cfg.index),
        .cfg_data         (cfg.data),
        .fail_count       (fail_count),
        .results_owed     (results_owed)
    );

    // 50 MHz clock.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Result back-pressure: random stall bursts, off when stall_pct is zero.
    initial
    begin
        res.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 99) < stall_pct)
            begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
            end
            res.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((smp.valid && smp.ready) || (res.valid && res.ready) ||
                (cfg.valid && cfg.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One sample transfer, optionally after an idle burst.
    task automatic send_x(input logic signed [X_W-1:0] x);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            smp.valid <= 1'b0;
            repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
        end
        smp.valid   <= 1'b1;
        smp.x_value <= x;
        do @(posedge clk); while (!smp.ready);
    endtask

    // Hold off new samples until every outstanding result has come back.
    task automatic drain();
        smp.valid <= 1'b0;
        do @(posedge clk); while (results_owed != 0);
    endtask

    // One register transfer on the configuration channel.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge clk); while (!cfg.ready);
    endtask

    // Load a full coefficient set, with a stray write to an unused index first.
    task automatic load_coefs(input coef_set_t set);
        write_reg(CFG_IDX_W'($urandom_range(COEF_REGS, 2 ** CFG_IDX_W - 1)), $urandom);
        for (int i = 0; i < COEF_REGS; i++)
            write_reg(CFG_IDX_W'(i), set[i]);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic signed [X_W-1:0] random_x();
        case ($urandom_range(0, 3))
            0: return X_W'($urandom);
            1: return X_W'($urandom_range(0, 1024) - 512);
            2:
            begin
                case ($urandom_range(0, 6))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh0100;
                    3: return -16'sh0100;
                    4: return 16'sh0001;
                    5: return -16'sh0001;
                    default: return 16'sh0000;
                endcase
            end
            default: return X_W'($urandom_range(0, 8192) - 4096);
        endcase
    endfunction

    // Tame sets shrink with the power so most sums stay inside the range.
    function automatic coef_set_t random_coef_set();
        coef_set_t set;
        logic      tame;
        int        span;
        tame = ($urandom_range(0, 2) == 0);
        for (int j = 0; j < COEF_REGS; j++)
        begin
            span = 2 ** (24 - 3 * j);
            case (tame ? 3 : $urandom_range(0, 3))
                0: set[j] = $urandom;
                1: set[j] = $urandom_range(0, 2 ** 17) - 2 ** 16;
                2:
                begin
                    case ($urandom_range(0, 4))
                        0: set[j] = 32'h7FFF_FFFF;
                        1: set[j] = 32'h8000_0000;
                        2: set[j] = 32'h0000_0001;
                        3: set[j] = 32'hFFFF_FFFF;
                        default: set[j] = 32'h0000_0000;
                    endcase
                end
                default: set[j] = $urandom_range(0, 2 * span) - span;
            endcase
        end
        return set;
    endfunction

    // Reset, directed cases, random sets, then the verdict.
    initial
    begin
        coef_set_t set;
        rst_n        = 1'b0;
        quiet_cycles = 0;
        gap_pct      = 20;
        stall_pct    = 20;
        smp.valid    = 1'b0;
        smp.x_value  = '0;
        cfg.valid    = 1'b0;
        cfg.index    = '0;
        cfg.data     = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Coefficients straight out of reset are all zero.
        send_x(16'sh0000);
        send_x(16'sh7FFF);
        send_x(16'sh8000);
        drain();

        // All ones: power saturation at large x, and x = 16.0 where only an eighth
        // power would overflow.
        set = '{default: 32'h0001_0000};
        load_coefs(set);
        send_x(16'sh0000);
        send_x(16'sh0100);
        send_x(-16'sh0100);
        send_x(16'sh0001);
        send_x(-16'sh0001);
        send_x(16'sh7FFF);
        send_x(16'sh8000);
        send_x(16'sh1000);
        send_x(-16'sh1000);
        send_x(16'sh2000);
        drain();

        // Largest coefficients drive the sum into its upper and lower bounds.
        set = '{default: 32'h7FFF_FFFF};
        load_coefs(set);
        send_x(16'sh7FFF);
        send_x(16'sh8000);
        send_x(16'sh0100);
        send_x(16'sh0000);
        drain();

        set = '{default: 32'h8000_0000};
        load_coefs(set);
        send_x(16'sh7FFF);
        send_x(16'sh8000);
        send_x(-16'sh0001);
        drain();

        set = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        load_coefs(set);
        send_x(16'sh0080);
        drain();

        // Random coefficient sets; the last one runs with no idling at all.
        for (int s = 0; s < SET_COUNT; s++)
        begin
            load_coefs(random_coef_set());
            if (s == SET_COUNT - 1)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    2: gap_pct = 30;
                    default: gap_pct = 60;
                endcase
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    2: stall_pct = 30;
                    default: stall_pct = 60;
                endcase
            end
            for (int n = 0; n < SAMPLES_PER_SET; n++)
                send_x(random_x());
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pe_pkg.sv
rtl/pe_if.sv
rtl/pe_cell.sv
rtl/polynomial_evaluator.sv
sim/polynomial_evaluator_checker.sv
sim/polynomial_evaluator_tb.sv
